### rtl/keypad_password_lock_defines.svh
// Assertion macros for the keypad password lock.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef KEYPAD_PASSWORD_LOCK_DEFINES_SVH
`define KEYPAD_PASSWORD_LOCK_DEFINES_SVH

// Plain property checked on every clock edge outside of reset.
`define KPL_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("keypad password lock: assertion failed");

// Implication checked in the same cycle.
`define KPL_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("keypad password lock: implication failed");

`endif

### rtl/kpl_pkg.sv
// Shared types, constants and tables for the keypad password lock.
// No dependencies; every module of the design imports this package.
package kpl_pkg;

  localparam int CodeLength = 6;
  localparam int IdxW       = (CodeLength > 1) ? $clog2(CodeLength) : 1;
  localparam int PosW       = $clog2(CodeLength + 1);
  localparam int NumKeys    = 16;
  localparam int KeyW       = 4;

  localparam logic [KeyW-1:0] KEY_HASH = 4'd0;
  localparam logic [KeyW-1:0] KEY_STAR = 4'd1;

  localparam logic CFG_MAX_FAILURES = 1'b0;
  localparam logic CFG_LONG_PRESS   = 1'b1;

  localparam logic [3:0]  MAX_FAILURES_RST = 4'd3;
  localparam logic [15:0] LONG_PRESS_RST   = 16'd5;
  localparam logic [2:0]  EXP_MAX          = 3'd7;

  typedef enum logic [3:0] {
    EV_STORED  = 4'd0,
    EV_DELETED = 4'd1,
    EV_GRANTED = 4'd2,
    EV_DENIED  = 4'd3,
    EV_LOCKOUT = 4'd4,
    EV_CHANGE  = 4'd5,
    EV_OLD_OK  = 4'd6,
    EV_OLD_BAD = 4'd7,
    EV_UPDATED = 4'd8,
    EV_IGNORED = 4'd9
  } kpl_event_e;

  typedef struct packed {
    logic [7:0]  raw_scan;
    logic [15:0] hold_count;
  } kpl_in_t;

  typedef struct packed {
    logic [3:0] event_code;
    logic [2:0] entry_position;
    logic [2:0] lockout_shift;
    logic       change_requested;
  } kpl_out_t;

  typedef struct packed {
    logic [3:0]  max_failures;
    logic [15:0] long_press_threshold;
  } kpl_cfg_t;

  typedef struct packed {
    logic            hit;
    logic [KeyW-1:0] idx;
  } kpl_key_t;

  // Active-low row/column scan byte of each key, by key index.
  function automatic logic [7:0] scan_code(input logic [KeyW-1:0] k);
    logic [7:0] c;
    unique case (k)
      4'd0:    c = 8'hEE;
      4'd1:    c = 8'hED;
      4'd2:    c = 8'hEB;
      4'd3:    c = 8'hE7;
      4'd4:    c = 8'hDE;
      4'd5:    c = 8'hDD;
      4'd6:    c = 8'hDB;
      4'd7:    c = 8'hD7;
      4'd8:    c = 8'hBE;
      4'd9:    c = 8'hBD;
      4'd10:   c = 8'hBB;
      4'd11:   c = 8'hB7;
      4'd12:   c = 8'h7E;
      4'd13:   c = 8'h7D;
      4'd14:   c = 8'h7B;
      default: c = 8'h77;
    endcase
    return c;
  endfunction

  // Factory password, repeated when the code is longer than six symbols.
  function automatic logic [KeyW-1:0] default_code(input int k);
    logic [KeyW-1:0] c;
    unique case (k % 6)
      0:       c = 4'd15;
      1:       c = 4'd14;
      2:       c = 4'd13;
      3:       c = 4'd11;
      4:       c = 4'd10;
      default: c = 4'd9;
    endcase
    return c;
  endfunction

endpackage

### rtl/kpl_decode.sv
// Scan byte decoder: maps the raw keypad scan byte to a key index.
// Depends on kpl_pkg for the scan code table.
module kpl_decode import kpl_pkg::*; (
  input  logic [7:0] raw_scan_i,
  output kpl_key_t   key_o
);

  always_comb begin
    key_o = '0;
    for (int k = 0; k < NumKeys; k++) begin
      if (raw_scan_i == scan_code(KeyW'(k))) begin
        key_o.hit = 1'b1;
        key_o.idx = KeyW'(k);
      end
    end
  end

endmodule

### rtl/kpl_core.sv
// Lock state and the single-pass next-state logic for one key item.
// Depends on kpl_pkg and kpl_decode.
module kpl_core import kpl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     advance_i,
  input  kpl_in_t  item_i,
  input  kpl_cfg_t cfg_i,
  output kpl_out_t res_o
);

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_VERIFY = 2'd1,
    MODE_NEW    = 2'd2
  } mode_e;

  kpl_key_t        key;
  logic [KeyW-1:0] buf_q   [CodeLength];
  logic [KeyW-1:0] pwd_q   [CodeLength];
  logic [KeyW-1:0] cmp_buf [CodeLength];
  logic [PosW-1:0] pos_q, pos_d;
  logic            pend_q, pend_d;
  logic            flag_q, flag_d;
  mode_e           mode_q, mode_d;
  logic [3:0]      fail_q, fail_d, fail_inc;
  logic [2:0]      exp_q, exp_d;
  logic            wr_en, do_check, match, mode_normal;
  kpl_event_e      ev;

  kpl_decode u_decode (
    .raw_scan_i(item_i.raw_scan),
    .key_o     (key)
  );

  // Buffer as it stands after this item's symbol is written.
  always_comb begin
    match = 1'b1;
    for (int k = 0; k < CodeLength; k++) begin
      cmp_buf[k] = (wr_en && pos_q[IdxW-1:0] == IdxW'(k)) ? key.idx : buf_q[k];
      if (cmp_buf[k] != pwd_q[k]) begin
        match = 1'b0;
      end
    end
  end

  assign fail_inc    = fail_q + 4'd1;
  assign mode_normal = (mode_q != MODE_VERIFY) && (mode_q != MODE_NEW);

  always_comb begin
    pos_d    = pos_q;
    pend_d   = pend_q;
    flag_d   = flag_q;
    mode_d   = mode_q;
    fail_d   = fail_q;
    exp_d    = exp_q;
    wr_en    = 1'b0;
    do_check = 1'b0;
    ev       = EV_IGNORED;
    if (key.hit) begin
      if (item_i.hold_count >= cfg_i.long_press_threshold) begin
        flag_d = 1'b1;
      end
      if (key.idx == KEY_STAR) begin
        if (pos_q != '0) begin
          pos_d = pos_q - PosW'(1);
          ev    = EV_DELETED;
        end
      end else if (key.idx == KEY_HASH) begin
        if (flag_d && mode_normal) begin
          mode_d = MODE_VERIFY;
          pos_d  = '0;
          ev     = EV_CHANGE;
        end else begin
          pend_d   = 1'b1;
          do_check = (pos_q == PosW'(CodeLength));
        end
      end else if (pos_q < PosW'(CodeLength)) begin
        wr_en    = 1'b1;
        pos_d    = pos_q + PosW'(1);
        ev       = EV_STORED;
        do_check = pend_q && (pos_d == PosW'(CodeLength));
      end
    end

    if (do_check) begin
      pend_d = 1'b0;
      pos_d  = '0;
      unique case (mode_q)
        MODE_NEW: begin
          mode_d = MODE_NORMAL;
          flag_d = 1'b0;
          ev     = EV_UPDATED;
        end
        MODE_VERIFY: begin
          if (match) begin
            mode_d = MODE_NEW;
            ev     = EV_OLD_OK;
          end else begin
            mode_d = MODE_NORMAL;
            flag_d = 1'b0;
            ev     = EV_OLD_BAD;
          end
        end
        default: begin
          if (flag_d) begin
            ev = match ? EV_OLD_OK : EV_OLD_BAD;
          end else if (match) begin
            ev = EV_GRANTED;
          end else if (fail_inc >= cfg_i.max_failures) begin
            fail_d = '0;
            exp_d  = (exp_q != EXP_MAX) ? exp_q + 3'd1 : exp_q;
            ev     = EV_LOCKOUT;
          end else begin
            fail_d = fail_inc;
            ev     = EV_DENIED;
          end
        end
      endcase
    end
  end

  assign res_o.event_code       = 4'(ev);
  assign res_o.entry_position   = 3'(pos_d);
  assign res_o.lockout_shift    = exp_d;
  assign res_o.change_requested = flag_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      pend_q <= 1'b0;
      flag_q <= 1'b0;
      mode_q <= MODE_NORMAL;
      fail_q <= '0;
      exp_q  <= '0;
      for (int k = 0; k < CodeLength; k++) begin
        pwd_q[k] <= default_code(k);
      end
    end else if (advance_i) begin
      pos_q  <= pos_d;
      pend_q <= pend_d;
      flag_q <= flag_d;
      mode_q <= mode_d;
      fail_q <= fail_d;
      exp_q  <= exp_d;
      if (do_check && mode_q == MODE_NEW) begin
        for (int k = 0; k < CodeLength; k++) begin
          pwd_q[k] <= cmp_buf[k];
        end
      end
    end
  end

  // Entry buffer holds no reset value; entries are read only once all are written.
  always_ff @(posedge clk_i) begin
    if (advance_i && wr_en) begin
      buf_q[pos_q[IdxW-1:0]] <= key.idx;
    end
  end

endmodule

### rtl/keypad_password_lock.sv
// Top level of the keypad password lock: input register, configuration
// registers, result register. Depends on kpl_pkg, kpl_core and the defines header.
//
//   Channel   Direction  Handshake               Payload
//   in        input      in_valid_i/in_stall_o   in_data_i  (kpl_in_t)
//   out       output     out_valid_o/out_stall_i out_data_o (kpl_out_t)
//   cfg       input      cfg_we_i                cfg_addr_i, cfg_wdata_i
//
// One item per cycle when the output does not stall: an item waits in the input
// register, then is decoded and applied to the lock state as its result is registered.
// The input register refills in the same cycle it drains, so throughput is one
// item per clock when the output side does not stall.
// Reset restores the factory password, clears all counters and flags, and
// loads the configuration defaults. A stalled output holds its result and the
// input stalls only while a waiting item cannot move into the result register.
`include "keypad_password_lock_defines.svh"

module keypad_password_lock import kpl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  kpl_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output kpl_out_t    out_data_o,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [15:0] cfg_wdata_i
);

  kpl_in_t  in_q;
  logic     in_valid_q;
  kpl_out_t out_q;
  logic     out_valid_q;
  kpl_cfg_t cfg_q;
  kpl_out_t res;
  logic     advance;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  kpl_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .advance_i(advance),
    .item_i   (in_q),
    .cfg_i    (cfg_q),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cfg_q.max_failures         <= MAX_FAILURES_RST;
      cfg_q.long_press_threshold <= LONG_PRESS_RST;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CFG_MAX_FAILURES: cfg_q.max_failures         <= cfg_wdata_i[3:0];
          CFG_LONG_PRESS:   cfg_q.long_press_threshold <= cfg_wdata_i;
          default:          ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The input side stalls only behind a stalled, full result register.
  `KPL_ASSERT_IMPLY(a_stall_cause, in_stall_o, out_valid_o && out_stall_i)
  // A grant, a denial or a password update always resets the entry position.
  `KPL_ASSERT_IMPLY(a_check_clears, out_valid_o && (out_data_o.event_code == EV_GRANTED
    || out_data_o.event_code == EV_DENIED || out_data_o.event_code == EV_UPDATED),
    out_data_o.entry_position == '0)
  // A lockout leaves a nonzero wait exponent.
  `KPL_ASSERT_IMPLY(a_lockout_shift, out_valid_o && out_data_o.event_code == EV_LOCKOUT,
    out_data_o.lockout_shift != '0)
  // A result is loaded only from a waiting item.
  `KPL_ASSERT_IMPLY(a_result_source, $rose(out_valid_o), $past(in_valid_q))

endmodule
